// ===== rtl/ssp_pkg.sv =====
// -----------------------------------------------------------------------------
// Servo status packet parser package
// Shared types and constants for the status packet parser and its scaler.
// -----------------------------------------------------------------------------
package ssp_pkg;

	// Parser phase, one per byte position in the status packet.
	typedef enum logic [2:0] {
		PH_HDR1,
		PH_HDR2,
		PH_ID,
		PH_LEN,
		PH_ERR,
		PH_POS_LO,
		PH_POS_HI,
		PH_CSUM
	} phase_t;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] pos_t;
	typedef logic [14:0] angle_t;
	// Product of a position and the angle multiplier.
	typedef logic [24:0] prod_t;
	// Wider accumulator for the reciprocal estimate and the remainder.
	typedef logic [25:0] acc_t;

	// Accepted packet handed from the parser to the angle scaler.
	typedef struct packed {
		byte_t id;
		pos_t  pos;
	} pkt_t;

	localparam byte_t       HDR_BYTE    = 8'hFF;
	localparam logic [8:0]  ANGLE_MUL   = 9'd300;
	localparam logic [9:0]  ANGLE_DIV   = 10'd1023;
	localparam angle_t      ANGLE_MAX   = 15'd19218;
	localparam int unsigned DIV_SHIFT   = 10;

endpackage

// ===== rtl/ssp_if.sv =====
// -----------------------------------------------------------------------------
// Servo status packet parser channels
// Valid/ready channels for received bytes and for parsed status results.
// -----------------------------------------------------------------------------
interface ssp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ssp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  servo_id;
	logic [15:0] position_raw;
	logic [14:0] angle;

	modport source (output valid, output servo_id, output position_raw, output angle,
		input ready);
	modport sink   (input valid, input servo_id, input position_raw, input angle,
		output ready);
endinterface

// ===== rtl/ssp_parser.sv =====
// -----------------------------------------------------------------------------
// Status packet byte parser
// Registers each received byte, walks the packet phases and hands a checked
// packet (id and position) to the next stage.
// -----------------------------------------------------------------------------
module ssp_parser (
	input  logic          clk,
	input  logic          arst_n,
	ssp_in_if.sink        rx,
	output logic          pkt_valid,
	output ssp_pkg::pkt_t pkt,
	input  logic          pkt_ready
);

	logic             v_s1;
	ssp_pkg::byte_t   byte_s1;
	logic             v_s2;
	ssp_pkg::pkt_t    pkt_s2;

	ssp_pkg::phase_t  phase_q;
	ssp_pkg::phase_t  phase_d;
	ssp_pkg::byte_t   id_q;
	ssp_pkg::byte_t   err_q;
	ssp_pkg::byte_t   pos_lo_q;
	ssp_pkg::byte_t   pos_hi_q;
	ssp_pkg::byte_t   sum_q;
	ssp_pkg::byte_t   sum_d;

	logic rdy1;
	logic rdy2;
	logic consume;
	logic pkt_ok;

	assign rdy2     = !v_s2 || pkt_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign rx.ready = rdy1;
	assign consume  = v_s1 && rdy2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rdy1) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (consume) begin
			unique case (phase_q)
				ssp_pkg::PH_HDR1: begin
					if (byte_s1 == ssp_pkg::HDR_BYTE) begin
						phase_d = ssp_pkg::PH_HDR2;
					end
				end
				ssp_pkg::PH_HDR2: begin
					phase_d = (byte_s1 == ssp_pkg::HDR_BYTE) ? ssp_pkg::PH_ID
						: ssp_pkg::PH_HDR1;
				end
				ssp_pkg::PH_ID:     phase_d = ssp_pkg::PH_LEN;
				ssp_pkg::PH_LEN:    phase_d = ssp_pkg::PH_ERR;
				ssp_pkg::PH_ERR:    phase_d = ssp_pkg::PH_POS_LO;
				ssp_pkg::PH_POS_LO: phase_d = ssp_pkg::PH_POS_HI;
				ssp_pkg::PH_POS_HI: phase_d = ssp_pkg::PH_CSUM;
				ssp_pkg::PH_CSUM:   phase_d = ssp_pkg::PH_HDR1;
				default:            phase_d = ssp_pkg::PH_HDR1;
			endcase
		end
	end

	// Running checksum and the packet check on the checksum byte.
	always_comb begin
		sum_d  = sum_q;
		pkt_ok = 1'b0;
		unique case (phase_q) inside
			ssp_pkg::PH_ID: begin
				sum_d = byte_s1;
			end
			ssp_pkg::PH_LEN, ssp_pkg::PH_ERR, ssp_pkg::PH_POS_LO, ssp_pkg::PH_POS_HI: begin
				sum_d = sum_q + byte_s1;
			end
			ssp_pkg::PH_CSUM: begin
				pkt_ok = (err_q == '0) && (byte_s1 == ~sum_q);
			end
			default: begin
				sum_d = sum_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ssp_pkg::PH_HDR1;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Packet fields are always written before the checksum phase reads them.
	always_ff @(posedge clk) begin
		if (consume) begin
			sum_q <= sum_d;
			unique case (phase_q)
				ssp_pkg::PH_ID:     id_q     <= byte_s1;
				ssp_pkg::PH_ERR:    err_q    <= byte_s1;
				ssp_pkg::PH_POS_LO: pos_lo_q <= byte_s1;
				ssp_pkg::PH_POS_HI: pos_hi_q <= byte_s1;
				default: begin
				end
			endcase
		end
	end

	// Result register toward the scaler.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1 && pkt_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && pkt_ok) begin
			pkt_s2.id  <= id_q;
			pkt_s2.pos <= {pos_hi_q, pos_lo_q};
		end
	end

	assign pkt_valid = v_s2;
	assign pkt       = pkt_s2;

`ifndef SYNTHESIS
	a_csum_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && phase_q == ssp_pkg::PH_CSUM) |=> phase_q == ssp_pkg::PH_HDR1)
		else $error("parser did not return to header hunt after checksum byte");

	a_pkt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !pkt_ready) |=> (v_s2 && $stable(pkt_s2)))
		else $error("stalled packet changed or was dropped");
`endif

endmodule

// ===== rtl/ssp_angle_scale.sv =====
// -----------------------------------------------------------------------------
// Position to angle scaler
// Three register stages: multiply by 300, reciprocal estimate of the divide
// by 1023, then a single correction step into the output register.
// -----------------------------------------------------------------------------
module ssp_angle_scale (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pkt_valid,
	input  ssp_pkg::pkt_t pkt,
	output logic          pkt_ready,
	ssp_out_if.source     status
);

	logic              v_s3;
	logic              v_s4;
	logic              v_s5;
	ssp_pkg::byte_t    id_s3;
	ssp_pkg::byte_t    id_s4;
	ssp_pkg::byte_t    id_s5;
	ssp_pkg::pos_t     pos_s3;
	ssp_pkg::pos_t     pos_s4;
	ssp_pkg::pos_t     pos_s5;
	ssp_pkg::prod_t    prod_s3;
	ssp_pkg::prod_t    prod_s4;
	ssp_pkg::angle_t   est_s4;
	ssp_pkg::angle_t   angle_s5;

	ssp_pkg::acc_t     acc_d;
	ssp_pkg::acc_t     rem_d;
	ssp_pkg::angle_t   angle_d;

	logic rdy3;
	logic rdy4;
	logic rdy5;

	assign rdy5      = !v_s5 || status.ready;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign pkt_ready = rdy3;

	// p / 1023 = (p / 1024) * (1 + 2^-10 + 2^-20 + ...); the truncated series
	// never overshoots and falls short by at most one.
	always_comb begin
		acc_d = ssp_pkg::acc_t'(prod_s3)
			+ ssp_pkg::acc_t'(prod_s3 >> ssp_pkg::DIV_SHIFT)
			+ ssp_pkg::acc_t'(prod_s3 >> (2 * ssp_pkg::DIV_SHIFT));
	end

	always_comb begin
		rem_d = ssp_pkg::acc_t'(prod_s4)
			- (ssp_pkg::acc_t'(est_s4) << ssp_pkg::DIV_SHIFT)
			+ ssp_pkg::acc_t'(est_s4);
		angle_d = est_s4
			+ ssp_pkg::angle_t'(rem_d >= ssp_pkg::acc_t'(ssp_pkg::ANGLE_DIV));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy3) begin
				v_s3 <= pkt_valid;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_valid && rdy3) begin
			id_s3   <= pkt.id;
			pos_s3  <= pkt.pos;
			prod_s3 <= ssp_pkg::prod_t'(pkt.pos) * ssp_pkg::prod_t'(ssp_pkg::ANGLE_MUL);
		end
		if (v_s3 && rdy4) begin
			id_s4   <= id_s3;
			pos_s4  <= pos_s3;
			prod_s4 <= prod_s3;
			est_s4  <= ssp_pkg::angle_t'(acc_d >> ssp_pkg::DIV_SHIFT);
		end
		if (v_s4 && rdy5) begin
			id_s5    <= id_s4;
			pos_s5   <= pos_s4;
			angle_s5 <= angle_d;
		end
	end

	assign status.valid        = v_s5;
	assign status.servo_id     = id_s5;
	assign status.position_raw = pos_s5;
	assign status.angle        = angle_s5;

`ifndef SYNTHESIS
	a_est_close: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (rem_d < ssp_pkg::acc_t'({ssp_pkg::ANGLE_DIV, 1'b0})))
		else $error("reciprocal estimate is more than one below the quotient");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (angle_s5 <= ssp_pkg::ANGLE_MAX))
		else $error("angle out of range");
`endif

endmodule

// ===== rtl/servo_status_packet_parser.sv =====
// -----------------------------------------------------------------------------
// Servo status packet parser
// Usage:
//   rx     : valid/ready channel of received serial bytes, one byte per
//            transaction; ready is high whenever the pipeline can move.
//   status : valid/ready channel carrying servo_id, position_raw and angle
//            (position_raw * 300 / 1023, truncated) of each packet whose
//            error byte is zero and whose checksum matches.
//   Bytes that do not complete a good packet produce no transaction.
//   Throughput is one byte per cycle, sustained, as long as status is taken.
//   The result for a packet follows its checksum byte's transaction through
//   the input register, parse stage, multiply, reciprocal estimate and
//   correction into the output register.
//   When the receiver stalls, results wait in the pipeline registers; rx
//   keeps taking bytes until a stalled packet blocks the parse stage.
//   Reset (arst_n low) empties the pipeline and restarts the hunt for the
//   first header byte.
// -----------------------------------------------------------------------------
module servo_status_packet_parser (
	input  logic      clk,
	input  logic      arst_n,
	ssp_in_if.sink    rx,
	ssp_out_if.source status
);

	logic          pkt_valid;
	logic          pkt_ready;
	ssp_pkg::pkt_t pkt;

	ssp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.pkt_valid (pkt_valid),
		.pkt       (pkt),
		.pkt_ready (pkt_ready)
	);

	ssp_angle_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt       (pkt),
		.pkt_ready (pkt_ready),
		.status    (status)
	);

endmodule

// ===== tb/sv/servo_status_packet_parser_tb.sv =====
// -----------------------------------------------------------------------------
// Servo status packet parser testbench
// Sends received bytes into the parser: a few hand-built packets first
// (broken header, extreme ids and positions, a nonzero error byte), then
// random packets mixed with noise, error packets, bad checksums and
// cut-off packets. A byte-level predictor works out each status result,
// and every result taken from the block is checked against the oldest
// awaited one. Both sides idle at random. The receiver also holds off
// long enough to back the parser up, and the sender drains once mid-run.
// -----------------------------------------------------------------------------
module servo_status_packet_parser_tb;
	import ssp_pkg::*;

	localparam int unsigned BODY_TARGET  = 1650;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned FORCED_HOLD  = 300;
	localparam int unsigned DRAIN_CYCLES = 16;

	typedef struct {
		byte_t  id;
		pos_t   pos;
		angle_t ang;
	} status_t;

	// Byte-level copy of the parser that queues the status it should emit.
	class status_packet_checker;
		phase_t      phase;
		byte_t       id_r;
		byte_t       err_r;
		byte_t       lo_r;
		byte_t       hi_r;
		byte_t       sum_r;
		status_t     awaited_status[$];
		int unsigned mismatches;
		int unsigned matched;

		function new();
			phase      = PH_HDR1;
			id_r       = 8'h00;
			err_r      = 8'h00;
			lo_r       = 8'h00;
			hi_r       = 8'h00;
			sum_r      = 8'h00;
			mismatches = 0;
			matched    = 0;
		endfunction

		function void note_rx_byte(byte_t b);
			status_t s;
			pos_t    pos;
			case (phase)
				PH_HDR1: begin
					if (b == HDR_BYTE)
						phase = PH_HDR2;
				end
				PH_HDR2: begin
					phase = (b == HDR_BYTE) ? PH_ID : PH_HDR1;
				end
				PH_ID: begin
					id_r  = b;
					sum_r = b;
					phase = PH_LEN;
				end
				PH_LEN: begin
					sum_r = sum_r + b;
					phase = PH_ERR;
				end
				PH_ERR: begin
					err_r = b;
					sum_r = sum_r + b;
					phase = PH_POS_LO;
				end
				PH_POS_LO: begin
					lo_r  = b;
					sum_r = sum_r + b;
					phase = PH_POS_HI;
				end
				PH_POS_HI: begin
					hi_r  = b;
					sum_r = sum_r + b;
					phase = PH_CSUM;
				end
				default: begin
					// The checksum byte ends the packet whether it is good or not.
					if (err_r == 8'h00 && b == byte_t'(~sum_r)) begin
						pos   = {hi_r, lo_r};
						s.id  = id_r;
						s.pos = pos;
						s.ang = angle_t'((32'(pos) * ANGLE_MUL) / ANGLE_DIV);
						awaited_status.push_back(s);
					end
					phase = PH_HDR1;
				end
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		task check_status(byte_t id, pos_t pos, angle_t ang);
			status_t s;
			bit      ok;
			if (awaited_status.size() == 0) begin
				report($sformatf("status id=%0d pos=%0d angle=%0d with none awaited",
					id, pos, ang));
				return;
			end
			s  = awaited_status.pop_front();
			ok = 1'b1;
			if (id !== s.id) begin
				report($sformatf("servo_id %0d, predicted %0d", id, s.id));
				ok = 1'b0;
			end
			if (pos !== s.pos) begin
				report($sformatf("position_raw %0d, predicted %0d (id %0d)", pos, s.pos, s.id));
				ok = 1'b0;
			end
			if (ang !== s.ang) begin
				report($sformatf("angle %0d, predicted %0d (position %0d)", ang, s.ang, s.pos));
				ok = 1'b0;
			end
			if (ok)
				matched++;
		endtask
	endclass

	logic clk;
	logic arst_n;

	ssp_in_if  rx_ch();
	ssp_out_if status_ch();

	servo_status_packet_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.status (status_ch)
	);

	status_packet_checker sb = new();

	bit          tx_burst;
	bit          rx_burst;
	int unsigned body_bytes;
	int unsigned noise_bytes;
	int unsigned n_err_pkts;
	int unsigned n_bad_csum;
	int unsigned n_cut_pkts;
	int unsigned n_taken;
	int unsigned input_stall_cycles;
	int unsigned max_hold;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none at all in a burst.
	function automatic int unsigned pick_gap(bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic byte_t pick_field();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return byte_t'($urandom_range(0, 255));
	endfunction

	// Entered at a rising edge; returns at the rising edge that ends the gap.
	task automatic send_byte(byte_t b);
		bit          taken;
		int unsigned gap;
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do begin
			@(negedge clk);
			taken = rx_ch.ready;
			@(posedge clk);
		end while (!taken);
		sb.note_rx_byte(b);
		gap = pick_gap(tx_burst);
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_packet(byte_t id, byte_t len, byte_t err, pos_t pos, bit corrupt);
		byte_t csum;
		csum = ~(id + len + err + pos[7:0] + pos[15:8]);
		if (corrupt)
			csum = csum ^ byte_t'($urandom_range(1, 255));
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(id);
		send_byte(len);
		send_byte(err);
		send_byte(pos[7:0]);
		send_byte(pos[15:8]);
		send_byte(csum);
		body_bytes += 8;
	endtask

	task automatic send_noise(byte_t b);
		send_byte(b);
		noise_bytes++;
	endtask

	task automatic wait_all_status();
		rx_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.awaited_status.size() != 0);
	endtask

	initial begin : stimulus
		int unsigned r;
		int unsigned cut_len;
		bit          paused;
		arst_n        <= 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Noise while hunting, then a header whose second byte restarts the hunt.
		send_noise(8'h00);
		send_noise(HDR_BYTE);
		send_noise(8'h7E);
		send_packet(8'hFF, 8'hFF, 8'h00, 16'hFFFF, 1'b0);
		send_packet(8'h00, 8'h00, 8'h00, 16'h0000, 1'b0);
		send_packet(8'h5A, 8'h04, 8'h80, 16'h0200, 1'b0);
		n_err_pkts++;

		paused = 1'b0;
		while (body_bytes < BODY_TARGET) begin
			if ($urandom_range(0, 11) == 0)
				tx_burst = !tx_burst;
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_packet(pick_field(), pick_field(), 8'h00,
					{pick_field(), pick_field()}, 1'b0);
			end else if (r < 80) begin
				send_packet(pick_field(), pick_field(), byte_t'($urandom_range(1, 255)),
					{pick_field(), pick_field()}, 1'b0);
				n_err_pkts++;
			end else if (r < 90) begin
				send_packet(pick_field(), pick_field(), 8'h00,
					{pick_field(), pick_field()}, 1'b1);
				n_bad_csum++;
			end else if (r < 95) begin
				// A packet cut short: the next packet's bytes finish it.
				cut_len = $urandom_range(1, 5);
				send_byte(HDR_BYTE);
				send_byte(HDR_BYTE);
				repeat (cut_len)
					send_byte(pick_field());
				body_bytes += 2 + cut_len;
				n_cut_pkts++;
			end else begin
				repeat ($urandom_range(1, 4))
					send_noise(byte_t'($urandom_range(0, 255)));
			end
			if (!paused && body_bytes >= BODY_TARGET / 2) begin
				paused = 1'b1;
				wait_all_status();
			end
		end
		wait_all_status();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d packet bytes and %0d noise bytes; %0d status results matched.",
			body_bytes, noise_bytes, sb.matched);
		$display("Dropped %0d error, %0d bad-checksum, %0d cut-off packets; rx stalled %0d cycles, longest hold-off %0d.",
			n_err_pkts, n_bad_csum, n_cut_pkts, input_stall_cycles, max_hold);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : receiver
		int unsigned hold;
		bit          taken;
		status_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			status_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				taken = status_ch.valid;
				@(posedge clk);
			end while (!taken);
			n_taken++;
			if ($urandom_range(0, 14) == 0)
				rx_burst = !rx_burst;
			// One long hold-off early on backs the pipeline up into the rx side.
			if (n_taken == 15)
				hold = FORCED_HOLD;
			else if ($urandom_range(0, 199) == 0)
				hold = $urandom_range(100, 250);
			else
				hold = pick_gap(rx_burst);
			if (hold != 0) begin
				if (hold > max_hold)
					max_hold = hold;
				status_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// Handshakes are sampled mid-cycle, where inputs and registered outputs are settled.
	initial begin : monitor
		bit     rx_take;
		bit     st_take;
		byte_t  got_id;
		pos_t   got_pos;
		angle_t got_ang;
		forever begin
			@(negedge clk);
			rx_take = rx_ch.valid && rx_ch.ready;
			st_take = status_ch.valid && status_ch.ready;
			if (rx_ch.valid && !rx_ch.ready)
				input_stall_cycles++;
			if (rx_take || st_take)
				idle_cycles = 0;
			else if (arst_n)
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles, %0d status results awaited",
					IDLE_LIMIT, sb.awaited_status.size());
				$display("Regression FAIL");
				$finish;
			end else if (st_take) begin
				got_id  = status_ch.servo_id;
				got_pos = status_ch.position_raw;
				got_ang = status_ch.angle;
				@(posedge clk);
				sb.check_status(got_id, got_pos, got_ang);
			end
		end
	end

endmodule
